@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lzwtb_pkg.sv @@
// shared types and constants for the lzw trie block compressor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lzwtb_pkg;

	localparam int LETTER_W  = 8;
	localparam int CODE_W    = 9;
	localparam int LETTERS_W = 16;
	localparam logic [LETTERS_W-1:0] LETTERS_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PARENT,
		ST_WALK,
		ST_MISS,
		ST_LINK
	} lzwtb_state_t;

	// result handed from the sequencer to the output register
	typedef struct packed {
		logic                 load;
		logic [CODE_W-1:0]    code;
		logic                 last;
		logic [LETTERS_W-1:0] letters;
	} lzwtb_emit_t;

endpackage

`default_nettype wire

@@ sv/lzwtb_node_ram.sv @@
// trie node memory: one write port, one read port, registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lzwtb_node_ram #(
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9,
	parameter int DATA_W = 26
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/lzwtb_ctrl.sv @@
// sequencer: sibling walk over the node memory, node append, block bookkeeping
// depends on lzwtb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lzwtb_ctrl #(
	parameter int DICT_ENTRIES = 512,
	parameter int BLOCK_CODES  = 64,
	parameter int ALPHABET     = 256,
	parameter int IDX_W        = 9,
	parameter int WORD_W       = 26
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [7:0]            letter,
	input  wire logic                  letter_valid,
	output logic                       letter_ready,
	input  wire logic                  out_free,
	output lzwtb_pkg::lzwtb_emit_t     emit,
	output logic                       rd_en,
	output logic [IDX_W-1:0]           rd_addr,
	input  wire logic [WORD_W-1:0]     rd_data,
	output logic                       wr_en,
	output logic [IDX_W-1:0]           wr_addr,
	output logic [WORD_W-1:0]          wr_data
);

	import lzwtb_pkg::*;

	localparam int CNT_W   = $clog2(DICT_ENTRIES + 1);
	localparam int CODES_W = $clog2(BLOCK_CODES + 1);
	localparam int RW      = $clog2(ALPHABET);

	lzwtb_state_t state_q, state_d;

	logic [LETTER_W-1:0]  let_q;
	logic [IDX_W-1:0]     cur_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     count_q;
	logic [CODES_W-1:0]   codes_q;
	logic [LETTERS_W-1:0] letters_q;
	logic [ALPHABET-1:0]  root_valid_q;
	logic [IDX_W-1:0]     link_addr_q;
	logic [WORD_W-1:0]    link_word_q;
	logic                 link_root_q;

	logic [LETTER_W-1:0]  let_sat;
	logic [LETTER_W-1:0]  rd_letter;
	logic [IDX_W-1:0]     rd_sib;
	logic [IDX_W-1:0]     rd_child;
	logic [IDX_W-1:0]     parent_child;
	logic [IDX_W-1:0]     fresh;
	logic                 cur_is_root;
	logic                 full;
	logic                 block_end;
	logic                 hit;
	logic                 finish;

	// node word: letter, next sibling, first child
	assign rd_letter = rd_data[WORD_W-1 -: LETTER_W];
	assign rd_sib    = rd_data[2*IDX_W-1 -: IDX_W];
	assign rd_child  = rd_data[IDX_W-1:0];

	assign let_sat = ({1'b0, letter} >= (LETTER_W + 1)'(ALPHABET)) ?
		LETTER_W'(ALPHABET - 1) : letter;

	assign cur_is_root = cur_q < IDX_W'(ALPHABET);
	// a root child link is stale unless written in this block
	assign parent_child = (cur_is_root && !root_valid_q[cur_q[RW-1:0]]) ? '0 : rd_child;
	assign fresh     = count_q[IDX_W-1:0];
	assign full      = count_q == CNT_W'(DICT_ENTRIES);
	assign block_end = codes_q == CODES_W'(BLOCK_CODES - 1);
	assign hit       = rd_letter == let_q;
	assign finish    = (state_q == ST_MISS && out_free && full) || state_q == ST_LINK;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (letter_valid) state_d = ST_PARENT;
			end
			ST_PARENT: begin
				state_d = (parent_child == '0) ? ST_MISS : ST_WALK;
			end
			ST_WALK: begin
				priority if (hit) state_d = ST_IDLE;
				else if (rd_sib == '0) state_d = ST_MISS;
				else state_d = ST_WALK;
			end
			ST_MISS: begin
				if (out_free) state_d = full ? ST_IDLE : ST_LINK;
			end
			ST_LINK: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		letter_ready = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = cur_q;
		wr_en        = 1'b0;
		wr_addr      = link_addr_q;
		wr_data      = link_word_q;
		emit.load    = 1'b0;
		emit.code    = cur_q[CODE_W-1:0];
		emit.last    = block_end;
		emit.letters = block_end ? letters_q : '0;
		unique case (state_q)
			ST_IDLE: begin
				letter_ready = 1'b1;
				rd_en        = letter_valid;
				rd_addr      = cur_q;
			end
			ST_PARENT: begin
				rd_en   = parent_child != '0;
				rd_addr = parent_child;
			end
			ST_WALK: begin
				rd_en   = !hit && rd_sib != '0;
				rd_addr = rd_sib;
			end
			ST_MISS: begin
				emit.load = out_free;
				wr_en     = out_free && !full;
				wr_addr   = fresh;
				wr_data   = {let_q, {IDX_W{1'b0}}, {IDX_W{1'b0}}};
			end
			ST_LINK: begin
				wr_en   = 1'b1;
				wr_addr = link_addr_q;
				wr_data = link_word_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			count_q      <= CNT_W'(ALPHABET);
			codes_q      <= '0;
			letters_q    <= LETTERS_W'(1);
			root_valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && letter_valid && letters_q != LETTERS_MAX) begin
				letters_q <= letters_q + LETTERS_W'(1);
			end
			if (state_q == ST_WALK && hit) begin
				cur_q <= idx_q;
			end
			if (state_q == ST_LINK) begin
				count_q <= count_q + CNT_W'(1);
				if (link_root_q) root_valid_q[link_addr_q[RW-1:0]] <= 1'b1;
			end
			if (finish) begin
				cur_q   <= {{(IDX_W - LETTER_W){1'b0}}, let_q};
				codes_q <= codes_q + CODES_W'(1);
				// block done: roots only, fresh count
				if (block_end) begin
					cur_q        <= '0;
					codes_q      <= '0;
					count_q      <= CNT_W'(ALPHABET);
					letters_q    <= LETTERS_W'(1);
					root_valid_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && letter_valid) begin
			let_q <= let_sat;
		end
		if (state_q == ST_PARENT) begin
			if (parent_child == '0) begin
				link_addr_q <= cur_q;
				link_word_q <= {rd_letter, rd_sib, fresh};
				link_root_q <= cur_is_root;
			end else begin
				idx_q <= parent_child;
			end
		end
		if (state_q == ST_WALK && !hit) begin
			if (rd_sib == '0) begin
				// tail of the sibling list gets the new node
				link_addr_q <= idx_q;
				link_word_q <= {rd_letter, fresh, rd_child};
				link_root_q <= 1'b0;
			end else begin
				idx_q <= rd_sib;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/lzw_trie_block_compressor_top.sv @@
// top level of the lzw trie block compressor: node memory, sequencer, output register
// depends on lzwtb_pkg, lzwtb_node_ram, lzwtb_ctrl
//
//  channel  signals                                   direction
//  letter   letter_valid, letter_ready, letter        in
//  code     code_valid, code_ready, code,             out
//           last_of_block, letters_in_block
//
// a hit walks the child list up to the matching node; a miss walks all n children,
// then emits the code and appends a node unless the table is full (n <= alphabet size)
// one memory read per step, the sibling list is walked one node per cycle
// reset needs no clearing pass: root child links are tracked by one valid bit per root
// a result waiting on code_ready holds the sequencer before the node append
`timescale 1ns / 1ps
`default_nettype none

module lzw_trie_block_compressor_top #(
	parameter int DICT_ENTRIES = 512,
	parameter int BLOCK_CODES  = 64,
	parameter int ALPHABET     = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        letter_valid,
	output logic             letter_ready,
	input  wire logic [7:0]  letter,
	output logic             code_valid,
	input  wire logic        code_ready,
	output logic [8:0]       code,
	output logic             last_of_block,
	output logic [15:0]      letters_in_block
);

	import lzwtb_pkg::*;

	localparam int IDX_W  = $clog2(DICT_ENTRIES);
	localparam int WORD_W = LETTER_W + 2 * IDX_W;

	lzwtb_emit_t       emit;
	logic              out_free;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;

	logic                 code_valid_q;
	logic [CODE_W-1:0]    code_q;
	logic                 last_q;
	logic [LETTERS_W-1:0] letters_q;

	assign out_free = !code_valid_q || code_ready;

	lzwtb_node_ram #(
		.DEPTH  (DICT_ENTRIES),
		.ADDR_W (IDX_W),
		.DATA_W (WORD_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lzwtb_ctrl #(
		.DICT_ENTRIES (DICT_ENTRIES),
		.BLOCK_CODES  (BLOCK_CODES),
		.ALPHABET     (ALPHABET),
		.IDX_W        (IDX_W),
		.WORD_W       (WORD_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.letter       (letter),
		.letter_valid (letter_valid),
		.letter_ready (letter_ready),
		.out_free     (out_free),
		.emit         (emit),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (emit.load) begin
			code_valid_q <= 1'b1;
		end else if (code_ready) begin
			code_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			code_q    <= emit.code;
			last_q    <= emit.last;
			letters_q <= emit.letters;
		end
	end

	assign code_valid       = code_valid_q;
	assign code             = code_q;
	assign last_of_block    = last_q;
	assign letters_in_block = letters_q;

endmodule

`default_nettype wire

@@ sv/lzwtb_checker.sv @@
// port-level checks for the lzw trie block compressor, bound to the top level
// depends on assert_macros.svh and lzw_trie_block_compressor_top
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lzwtb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        letter_valid,
	input wire logic        letter_ready,
	input wire logic [7:0]  letter,
	input wire logic        code_valid,
	input wire logic        code_ready,
	input wire logic [8:0]  code,
	input wire logic        last_of_block,
	input wire logic [15:0] letters_in_block
);

	logic letter_seen;
	assign letter_seen = letter_valid && (letter != 8'hxx || 1'b1);

	`CHK_NEXT(a_out_hold, code_valid && !code_ready, code_valid, "result dropped while stalled")
	`CHK_NEXT(a_out_stable, code_valid && !code_ready, $stable(code) && $stable(last_of_block) && $stable(letters_in_block), "result changed while stalled")
	`CHK_SAME(a_count_zero, code_valid && !last_of_block, letters_in_block == 16'd0, "letter count outside last code")
	`CHK_SAME(a_count_last, code_valid && last_of_block, letters_in_block >= 16'd2, "block letter count too small")
	`CHK_NEXT(a_busy_after_accept, letter_seen && letter_ready, !letter_ready, "ready right after a transaction")

endmodule

bind lzw_trie_block_compressor_top lzwtb_checker u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.letter_valid     (letter_valid),
	.letter_ready     (letter_ready),
	.letter           (letter),
	.code_valid       (code_valid),
	.code_ready       (code_ready),
	.code             (code),
	.last_of_block    (last_of_block),
	.letters_in_block (letters_in_block)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// self-checking bench for lzw_trie_block_compressor_top: directed table, then random letter phrases
// depends on lzwtb_pkg and the compressor rtl; predicts codes with a behavioral trie of its own, bar hand-set rows
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import lzwtb_pkg::*;

	localparam int DICT_N       = 512;
	localparam int ROOT_N       = 256;
	localparam int BLOCK_N      = 64;
	localparam int RANDOM_ITEMS = 900;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 300;
	localparam int QUIET_LIMIT  = 4000;

	typedef struct packed {
		logic [CODE_W-1:0]    code;
		logic                 last;
		logic [LETTERS_W-1:0] letters;
	} code_txn_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_NO_CODE,
		ROW_CODE
	} row_kind_t;

	typedef struct packed {
		logic [LETTER_W-1:0]  letter;
		row_kind_t            kind;
		logic [CODE_W-1:0]    code;
		logic                 last;
		logic [LETTERS_W-1:0] letters;
	} dir_row_t;

	// opening rows follow the trie by hand from reset: root 0 prefix, then 256.. appended
	localparam dir_row_t DIRECTED_ROWS [23] = '{
		'{8'h00, ROW_CODE,    9'd0,   1'b0, 16'd0},
		'{8'h00, ROW_NO_CODE, 9'd0,   1'b0, 16'd0},
		'{8'hFF, ROW_CODE,    9'd256, 1'b0, 16'd0},
		'{8'hFF, ROW_CODE,    9'd255, 1'b0, 16'd0},
		'{8'hFF, ROW_NO_CODE, 9'd0,   1'b0, 16'd0},
		'{8'hFF, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'hFF, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'hFF, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h00, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h00, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'hFF, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h55, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'hAA, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h01, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h80, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h7F, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'hFE, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h00, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h01, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h00, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h02, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h00, ROW_PREDICT, 9'd0,   1'b0, 16'd0},
		'{8'h01, ROW_PREDICT, 9'd0,   1'b0, 16'd0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 letter_valid = 1'b0;
	logic                 letter_ready;
	logic [LETTER_W-1:0]  letter = '0;
	logic                 code_valid;
	logic                 code_ready = 1'b0;
	logic [CODE_W-1:0]    code;
	logic                 last_of_block;
	logic [LETTERS_W-1:0] letters_in_block;

	// trie copy used for prediction
	logic [LETTER_W-1:0] trie_letter  [DICT_N];
	logic [CODE_W-1:0]   trie_sibling [DICT_N];
	logic [CODE_W-1:0]   trie_child   [DICT_N];
	int unsigned         trie_count;
	int unsigned         walk_code;
	int unsigned         block_codes;
	int unsigned         block_letters;

	code_txn_t pending_codes [$];
	int        mismatch_count = 0;
	int        random_sent = 0;
	int        idle_pct = 31;
	logic      hold_req = 1'b0;
	int        stall_left = 0;
	int        quiet_cycles = 0;

	lzw_trie_block_compressor_top #(
		.DICT_ENTRIES (DICT_N),
		.BLOCK_CODES  (BLOCK_N),
		.ALPHABET     (ROOT_N)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.letter_valid     (letter_valid),
		.letter_ready     (letter_ready),
		.letter           (letter),
		.code_valid       (code_valid),
		.code_ready       (code_ready),
		.code             (code),
		.last_of_block    (last_of_block),
		.letters_in_block (letters_in_block)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void trie_clear_block();
		for (int i = 0; i < ROOT_N; i++) begin
			trie_letter[i]  = LETTER_W'(i);
			trie_sibling[i] = '0;
			trie_child[i]   = '0;
		end
		trie_count    = ROOT_N;
		walk_code     = 0;
		block_codes   = 0;
		block_letters = 1;
	endfunction

	// advances the trie by one letter; returns 1 when a code comes out
	function automatic logic trie_step(input logic [LETTER_W-1:0] l, output code_txn_t res);
		int unsigned idx;
		int unsigned hit;
		int unsigned steps;
		int unsigned fresh;
		res = '0;
		// the alphabet covers every 8-bit letter, so no letter is clamped
		if (block_letters < LETTERS_MAX)
			block_letters++;
		hit = 0;
		idx = trie_child[walk_code];
		for (steps = 0; idx != 0 && hit == 0 && steps < DICT_N; steps++) begin
			if (trie_letter[idx] == l)
				hit = idx;
			else
				idx = trie_sibling[idx];
		end
		if (hit != 0) begin
			walk_code = hit;
			return 1'b0;
		end
		res.code = CODE_W'(walk_code);
		// with a full table the code still goes out, the trie just stops growing
		if (trie_count < DICT_N) begin
			fresh = trie_count;
			trie_count++;
			trie_letter[fresh]  = l;
			trie_sibling[fresh] = '0;
			trie_child[fresh]   = '0;
			if (trie_child[walk_code] == 0) begin
				trie_child[walk_code] = CODE_W'(fresh);
			end else begin
				idx = trie_child[walk_code];
				while (trie_sibling[idx] != 0)
					idx = trie_sibling[idx];
				trie_sibling[idx] = CODE_W'(fresh);
			end
		end
		walk_code = l;
		block_codes++;
		if (block_codes >= BLOCK_N) begin
			res.last    = 1'b1;
			res.letters = LETTERS_W'(block_letters);
			trie_clear_block();
		end
		return 1'b1;
	endfunction

	task automatic check_field(input string what, input int unsigned want_v, got_v);
		if (want_v != got_v) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
		end
	endtask

	// holds valid and payload until the transaction is taken
	task automatic send_letter(input logic [LETTER_W-1:0] l);
		if ($urandom_range(99) < idle_pct) begin
			letter_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		letter_valid <= 1'b1;
		letter <= l;
		do @(posedge clk); while (!letter_ready);
	endtask

	task automatic feed_letter(input logic [LETTER_W-1:0] l);
		code_txn_t res;
		send_letter(l);
		if (trie_step(l, res))
			pending_codes.push_back(res);
		random_sent++;
	endtask

	always @(posedge clk) begin : code_side
		code_txn_t want;
		if (arst_n && code_valid && code_ready) begin
			if (pending_codes.size() == 0) begin
				mismatch_count++;
				$display("%0t: code transaction, expected none, actual code %0d", $time, code);
			end else begin
				want = pending_codes.pop_front();
				check_field("code", want.code, code);
				check_field("last_of_block", want.last, last_of_block);
				check_field("letters_in_block", want.letters, letters_in_block);
			end
		end
		if (hold_req) begin
			stall_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			code_ready <= 1'b0;
		end else begin
			code_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((letter_valid && letter_ready) || (code_valid && code_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin : stimulus
		code_txn_t           res;
		logic                emits;
		logic [LETTER_W-1:0] pool [8];
		int                  mode;
		int                  n;
		int                  k;
		int                  plen;
		int                  reps;
		logic                hold_done;
		logic                pause_done;
		for (int i = 0; i < DICT_N; i++) begin
			trie_letter[i]  = '0;
			trie_sibling[i] = '0;
			trie_child[i]   = '0;
		end
		trie_clear_block();
		hold_done = 1'b0;
		pause_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r]) begin
			send_letter(DIRECTED_ROWS[r].letter);
			emits = trie_step(DIRECTED_ROWS[r].letter, res);
			case (DIRECTED_ROWS[r].kind)
				ROW_CODE: begin
					pending_codes.push_back({DIRECTED_ROWS[r].code, DIRECTED_ROWS[r].last,
						DIRECTED_ROWS[r].letters});
				end
				ROW_NO_CODE: begin
				end
				default: begin
					if (emits)
						pending_codes.push_back(res);
				end
			endcase
		end

		while (random_sent < RANDOM_ITEMS) begin
			// a quiet stretch with no idling on either side
			idle_pct = (random_sent >= 350 && random_sent < 550) ? 0 : 31;
			if (!hold_done && random_sent >= 150) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && random_sent >= 650) begin
				letter_valid <= 1'b0;
				@(posedge clk);
				while (pending_codes.size() != 0)
					@(posedge clk);
				pause_done = 1'b1;
			end
			mode = $urandom_range(99);
			if (mode < 25) begin
				// noise: uniform letters, mostly misses
				n = $urandom_range(40, 8);
				repeat (n) feed_letter(LETTER_W'($urandom_range(255)));
			end else if (mode < 55) begin
				// few distinct letters give long matches and long blocks
				k = $urandom_range(4, 2);
				for (int i = 0; i < 4; i++)
					pool[i] = LETTER_W'($urandom_range(255));
				n = $urandom_range(60, 20);
				repeat (n) feed_letter(pool[$urandom_range(k - 1)]);
			end else if (mode < 80) begin
				plen = $urandom_range(6, 2);
				for (int i = 0; i < plen; i++)
					pool[i] = LETTER_W'($urandom_range(255));
				reps = $urandom_range(10, 3);
				repeat (reps) begin
					for (int i = 0; i < plen; i++)
						feed_letter(pool[i]);
				end
			end else begin
				// one root collects many children, so sibling walks get long
				pool[0] = LETTER_W'($urandom_range(255));
				n = $urandom_range(40, 10);
				repeat (n) begin
					feed_letter(pool[0]);
					feed_letter(LETTER_W'($urandom_range(255)));
				end
			end
		end

		letter_valid <= 1'b0;
		@(posedge clk);
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
